>>> sv/pet_pkg.sv
// ----------------------------------------------------------------------------
// pet_pkg: shared types and constants of the pending entry table
// Operation and result codes, state codes, the scan token and cell flags.
// ----------------------------------------------------------------------------
package pet_pkg;

	localparam int SLOTS_DEF       = 16;
	localparam int KEY_WORDS_DEF   = 4;
	localparam int NONCE_WORDS_DEF = 4;

	localparam int WORD_W    = 64;
	localparam int MAX_WORDS = 4;
	localparam int OWNER_W   = 32;
	localparam int TIME_W    = 32;
	localparam int EXPIRY_W  = TIME_W + 1;
	localparam int LIFE_W    = 16;
	localparam int OP_W      = 2;
	localparam int STATUS_W  = 2;
	localparam int SLOT_W    = 4;

	localparam logic [LIFE_W-1:0] LIFETIME_RESET = 16'd60;

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 2'd0,
		OP_FIND   = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		RES_OK        = 2'd0,
		RES_NOT_FOUND = 2'd1,
		RES_PENDING   = 2'd2,
		RES_FULL      = 2'd3
	} res_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	// token handed from cell to cell, one cell per cycle
	typedef struct packed {
		logic act;        // token sits at this cell
		logic done;       // a live match was already hit upstream
		logic free_seen;  // a free slot was already seen upstream
	} tok_t;

	// per-cell report while the token is at that cell
	typedef struct packed {
		logic hit;
		logic free;
	} flag_t;

endpackage

>>> sv/pending_entry_table_with_expiry.sv
// ----------------------------------------------------------------------------
// pending_entry_table_with_expiry: table of pending entries with expiry
// A row of slot cells walked by a scan token, plus request and reply control.
//
// Usage:
//   Input channel (in_valid/in_ready): one request per transfer, carrying the
//   operation (add, find, remove), the name key, the owner id, the challenge
//   with its present flag and the current time in seconds.
//   Output channel (out_valid/out_ready): one reply per request, status plus
//   slot_index, in request order.
//   Config channel (cfg_valid/cfg_ready): writes lifetime_seconds; always
//   ready, write it only while the block is idle.
//   Scan: after the request transfer the token walks the SLOTS cells one per
//   cycle; when it has left the last cell, the done state writes the table
//   and loads the reply register, waiting there while that register is full.
//   One request is in flight at a time, so the next request is taken only
//   after the reply of the last one is loaded.
//   The reply sits in an output register: the next request is taken while it
//   waits. If the receiver stalls longer, the finished scan holds in its last
//   state until the reply register frees; nothing is lost.
//   Reset: all slots are empty, lifetime_seconds is 60, no reply is pending.
// ----------------------------------------------------------------------------
module pending_entry_table_with_expiry #(
	parameter int SLOTS       = pet_pkg::SLOTS_DEF,
	parameter int KEY_WORDS   = pet_pkg::KEY_WORDS_DEF,
	parameter int NONCE_WORDS = pet_pkg::NONCE_WORDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [pet_pkg::OP_W-1:0]        req_type,
	input  logic [pet_pkg::WORD_W-1:0]      key_word0,
	input  logic [pet_pkg::WORD_W-1:0]      key_word1,
	input  logic [pet_pkg::WORD_W-1:0]      key_word2,
	input  logic [pet_pkg::WORD_W-1:0]      key_word3,
	input  logic [pet_pkg::OWNER_W-1:0]     owner_id,
	input  logic [pet_pkg::WORD_W-1:0]      nonce_word0,
	input  logic [pet_pkg::WORD_W-1:0]      nonce_word1,
	input  logic [pet_pkg::WORD_W-1:0]      nonce_word2,
	input  logic [pet_pkg::WORD_W-1:0]      nonce_word3,
	input  logic                            nonce_present,
	input  logic [pet_pkg::TIME_W-1:0]      now_seconds,
	// reply channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [pet_pkg::STATUS_W-1:0]    status,
	output logic [pet_pkg::SLOT_W-1:0]      slot_index,
	// lifetime register write
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pet_pkg::LIFE_W-1:0]      cfg_data
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	pet_pkg::state_t state_q, state_d;

	// request held for the whole scan, broadcast to every cell
	logic [pet_pkg::OP_W-1:0]                      req_op_q;
	logic [KEY_WORDS-1:0][pet_pkg::WORD_W-1:0]     req_key_q;
	logic [pet_pkg::OWNER_W-1:0]                   req_owner_q;
	logic [pet_pkg::TIME_W-1:0]                    req_now_q;
	logic [NONCE_WORDS-1:0][pet_pkg::WORD_W-1:0]   req_nonce_q;
	logic                                          req_nonce_en_q;
	logic [pet_pkg::LIFE_W-1:0]                    lifetime_q;

	logic [pet_pkg::MAX_WORDS-1:0][pet_pkg::WORD_W-1:0] key_all, nonce_all;

	pet_pkg::tok_t start_q;
	logic [IW-1:0] pos_q;       // cell the token sits at during the scan
	logic          hit_q, free_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;

	logic                         out_valid_q;
	logic [pet_pkg::STATUS_W-1:0] status_q;
	logic [pet_pkg::SLOT_W-1:0]   slot_q;

	pet_pkg::tok_t  tok  [SLOTS+1];
	pet_pkg::flag_t flag [SLOTS];
	logic [SLOTS-1:0] hit_v, free_v, act_v, wr_en_v;

	logic accept, out_free, finish, wr_go, hit_any, free_any;
	logic [pet_pkg::EXPIRY_W-1:0] wr_expiry;
	pet_pkg::res_t res_status;
	logic [IW-1:0]   res_idx;
	logic [IW+3:0]   idx_ext;

	assign key_all   = {key_word3, key_word2, key_word1, key_word0};
	assign nonce_all = {nonce_word3, nonce_word2, nonce_word1, nonce_word0};

	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign slot_index = slot_q;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign hit_any  = |hit_v;
	assign free_any = |free_v;
	// new entry expiry in 33 bits, never wraps
	assign wr_expiry = {1'b0, req_now_q} + pet_pkg::EXPIRY_W'(lifetime_q);
	assign wr_go     = finish && (req_op_q == pet_pkg::OP_ADD) && !hit_q && free_q;

	// ---------------- cell row ----------------
	assign tok[0] = start_q;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		assign wr_en_v[i] = wr_go && (free_idx_q == IW'(i));
		assign hit_v[i]   = flag[i].hit;
		assign free_v[i]  = flag[i].free;
		assign act_v[i]   = tok[i].act;

		pet_cell #(
			.KEY_WORDS   (KEY_WORDS),
			.NONCE_WORDS (NONCE_WORDS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.tok_i       (tok[i]),
			.tok_o       (tok[i+1]),
			.flag        (flag[i]),
			.req_op      (req_op_q),
			.req_key     (req_key_q),
			.req_owner   (req_owner_q),
			.req_now     (req_now_q),
			.wr_en       (wr_en_v[i]),
			.wr_nonce_en (req_nonce_en_q),
			.wr_nonce    (req_nonce_q),
			.wr_expiry   (wr_expiry)
		);
	end

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pet_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		finish   = 1'b0;
		unique case (state_q)
			pet_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = pet_pkg::S_SCAN;
				end
			end
			pet_pkg::S_SCAN: begin
				// token has left the last cell
				if (tok[SLOTS].act) begin
					state_d = pet_pkg::S_DONE;
				end
			end
			pet_pkg::S_DONE: begin
				// write the new entry and load the reply together
				if (out_free) begin
					finish  = 1'b1;
					state_d = pet_pkg::S_IDLE;
				end
			end
			default: state_d = pet_pkg::S_IDLE;
		endcase
	end

	// reply decode
	always_comb begin
		res_status = pet_pkg::RES_NOT_FOUND;
		res_idx    = '0;
		case (req_op_q)
			pet_pkg::OP_ADD: begin
				if (hit_q) begin
					res_status = pet_pkg::RES_PENDING;
				end else if (free_q) begin
					res_status = pet_pkg::RES_OK;
					res_idx    = free_idx_q;
				end else begin
					res_status = pet_pkg::RES_FULL;
				end
			end
			pet_pkg::OP_FIND: begin
				if (hit_q) begin
					res_status = pet_pkg::RES_OK;
					res_idx    = hit_idx_q;
				end
			end
			pet_pkg::OP_REMOVE: res_status = pet_pkg::RES_OK;
			default:            res_status = pet_pkg::RES_NOT_FOUND;
		endcase
		idx_ext = {4'd0, res_idx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q  <= pet_pkg::LIFETIME_RESET;
			start_q     <= '0;
			pos_q       <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				lifetime_q <= cfg_data;
			end
			start_q <= '{act: accept, done: 1'b0, free_seen: 1'b0};
			if (accept) begin
				pos_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (state_q == pet_pkg::S_SCAN) begin
				if (pos_q != LAST) begin
					pos_q <= pos_q + 1'b1;
				end
				if (hit_any) begin
					hit_q <= 1'b1;
				end
				if (free_any) begin
					free_q <= 1'b1;
				end
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_op_q       <= req_type;
			req_key_q      <= key_all[KEY_WORDS-1:0];
			req_owner_q    <= owner_id;
			req_now_q      <= now_seconds;
			req_nonce_q    <= nonce_all[NONCE_WORDS-1:0];
			req_nonce_en_q <= nonce_present;
		end
		if (state_q == pet_pkg::S_SCAN) begin
			if (hit_any) begin
				hit_idx_q <= pos_q;
			end
			if (free_any) begin
				free_idx_q <= pos_q;
			end
		end
		if (finish) begin
			status_q <= res_status;
			slot_q   <= idx_ext[3:0];
		end
	end

	// ---------------- assertions ----------------
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(act_v))
		else $error("more than one cell holds the scan token");

	a_token_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> tok[0].act)
		else $error("request transfer did not launch the scan token");

	a_hit_free_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(hit_any && free_any))
		else $error("one cell reported both a hit and a free slot");

	a_write_only_add: assert property (@(posedge clk) disable iff (!arst_n)
		wr_go |-> (req_op_q == pet_pkg::OP_ADD) && !hit_q && free_q && $onehot(wr_en_v))
		else $error("table write without a free slot on an add miss");

	a_token_at_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pet_pkg::S_SCAN && (hit_any || free_any)) |-> act_v[pos_q])
		else $error("scan position does not follow the token");

endmodule

>>> sv/pet_cell.sv
// ----------------------------------------------------------------------------
// pet_cell: one slot of the pending entry table
// Holds one entry, checks it against the request while the token is here,
// frees it when an add or find meets it expired or a remove matches it, and passes the token on.
// ----------------------------------------------------------------------------
module pet_cell #(
	parameter int KEY_WORDS   = pet_pkg::KEY_WORDS_DEF,
	parameter int NONCE_WORDS = pet_pkg::NONCE_WORDS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  pet_pkg::tok_t                                 tok_i,
	output pet_pkg::tok_t                                 tok_o,
	output pet_pkg::flag_t                                flag,
	input  logic [pet_pkg::OP_W-1:0]                      req_op,
	input  logic [KEY_WORDS-1:0][pet_pkg::WORD_W-1:0]     req_key,
	input  logic [pet_pkg::OWNER_W-1:0]                   req_owner,
	input  logic [pet_pkg::TIME_W-1:0]                    req_now,
	input  logic                                          wr_en,
	input  logic                                          wr_nonce_en,
	input  logic [NONCE_WORDS-1:0][pet_pkg::WORD_W-1:0]   wr_nonce,
	input  logic [pet_pkg::EXPIRY_W-1:0]                  wr_expiry
);

	logic                                        live_q;
	logic [KEY_WORDS-1:0][pet_pkg::WORD_W-1:0]   key_q;
	logic [pet_pkg::OWNER_W-1:0]                 owner_q;
	logic [NONCE_WORDS-1:0][pet_pkg::WORD_W-1:0] nonce_q;
	logic [pet_pkg::EXPIRY_W-1:0]                expiry_q;
	pet_pkg::tok_t                               tok_q;

	logic key_hit, own_hit, expired, scan, drop, hit, rm, free;

	always_comb begin
		key_hit = live_q && (key_q == req_key);
		own_hit = (owner_q == req_owner);
		expired = (expiry_q <= {1'b0, req_now});
		scan    = tok_i.act && !tok_i.done &&
		          (req_op == pet_pkg::OP_ADD || req_op == pet_pkg::OP_FIND);
		// expired name match is dropped whatever its owner
		drop    = scan && key_hit && expired;
		hit     = scan && key_hit && !expired && own_hit;
		rm      = tok_i.act && (req_op == pet_pkg::OP_REMOVE) && key_hit && own_hit;
		free    = scan && !hit && !tok_i.free_seen && (!live_q || drop);
	end

	assign flag.hit  = hit;
	assign flag.free = free;
	assign tok_o     = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
			tok_q  <= '0;
		end else begin
			tok_q <= '{act: tok_i.act, done: tok_i.done | hit,
			           free_seen: tok_i.free_seen | free};
			if (wr_en) begin
				live_q <= 1'b1;
			end else if (drop || rm) begin
				live_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_q    <= req_key;
			owner_q  <= req_owner;
			expiry_q <= wr_expiry;
			if (wr_nonce_en) begin
				nonce_q <= wr_nonce;
			end
		end
	end

endmodule
